FILE: rtl/xxh_pkg.sv
// Package for the XXH64 stream hash core: primes, sequencer states, helpers.
package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  localparam logic [63:0] SEED_RESET = 64'd0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LANE_A,   // t = w * P2
    ST_LANE_B,   // lane = rotl(lane + t, 31) * P1
    ST_MERGE,    // h = sum of rotated lanes, or seed + P5 with no stripe
    ST_MRG_A,    // t = lane[i] * P2
    ST_MRG_B,    // t = rotl(t, 31) * P1
    ST_MRG_C,    // h = (h ^ t) * P1 + P4
    ST_LEN,      // h += total length
    ST_WRD_A,    // t = buf[i] * P2
    ST_WRD_B,    // t = rotl(t, 31) * P1
    ST_WRD_C,    // h = rotl(h ^ t, 27) * P1 + P4
    ST_QRT_A,    // t = tail32 * P1
    ST_QRT_B,    // h = rotl(h ^ t, 23) * P2 + P3
    ST_BYT_A,    // t = byte * P5
    ST_BYT_B,    // h = rotl(h ^ t, 11) * P1
    ST_AVL_A,    // h = (h ^ h >> 33) * P2
    ST_AVL_B,    // h = (h ^ h >> 29) * P3
    ST_AVL_C,    // h ^= h >> 32, emit
    ST_OUT
  } xxh_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

endpackage

FILE: rtl/xxh_mul64.sv
// Shared 64x64 low-half multiplier, split into 32-bit partial products held in registers.
module xxh_mul64 (
  input  logic        clk,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] lo_r;
  logic [31:0] cross_r;
  logic [31:0] cross_nxt;

  // form the low product and the two cross terms, then sum the upper half
  assign cross_nxt = a[31:0] * b[63:32] + a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      lo_r    <= a[31:0] * b[31:0];
      cross_r <= cross_nxt;
    end
  end

  assign p = {lo_r[63:32] + cross_r, lo_r[31:0]};
endmodule

FILE: rtl/xxh64_stream_hash_core.sv
// Top level of the XXH64 stream hash core: sequencer, lanes, buffer and shared multiplier.
// A non-last word joins the buffer; when it completes a stripe, the 4 lanes use the
// shared multiplier in turn, two dependent products each. A last item is finished by the
// merge of 4 lanes (3 products each), up to 3 buffered words, one 4-byte piece, up to 3
// bytes and avalanche, after its stripe if it completes one. in_ready is low until the
// sequencer is idle again, so no new item is taken while one is in progress.
// Reset (rst_n low, synchronous) loads seed and lanes from SEED_INIT, clears counts and length; buffer is unset.
module xxh64_stream_hash_core #(
  parameter logic [63:0] SEED_INIT = xxh_pkg::SEED_RESET
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash
);
  import xxh_pkg::*;

  xxh_state_t st_r, st_nxt;
  logic [63:0] seed_r;
  logic [63:0] lane_r [4];
  logic [63:0] buf_r [4];
  logic [1:0]  nbuf_r;
  logic [63:0] len_r;
  logic        seen_r;
  logic [63:0] h_r, t_r;
  logic [1:0]  idx_r;
  logic        ph_r;       // multiplier phase: 0 issue, 1 result ready
  logic [63:0] tail_r;
  logic [2:0]  tcnt_r;
  logic [63:0] hash_r;

  logic        acc;
  logic [3:0]  cnt;
  logic        mstart;
  logic [63:0] ma, mb, mp;

  assign acc = in_valid && in_ready;
  assign cnt = in_byte_count > 4'd8 ? 4'd8 : in_byte_count;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_hash  = hash_r;

  xxh_mul64 u_mul (.clk(clk), .start(mstart), .a(ma), .b(mb), .p(mp));

  // select multiplier operands per step; issue on phase 0
  always_comb begin
    ma = t_r;
    mb = PRIME1;
    unique case (st_r)
      ST_LANE_A: begin ma = buf_r[idx_r]; mb = PRIME2; end
      ST_LANE_B: begin ma = rotl64(lane_r[idx_r] + t_r, 31); mb = PRIME1; end
      ST_MRG_A:  begin ma = lane_r[idx_r]; mb = PRIME2; end
      ST_MRG_B:  begin ma = rotl64(t_r, 31); mb = PRIME1; end
      ST_MRG_C:  begin ma = h_r ^ t_r; mb = PRIME1; end
      ST_WRD_A:  begin ma = buf_r[idx_r]; mb = PRIME2; end
      ST_WRD_B:  begin ma = rotl64(t_r, 31); mb = PRIME1; end
      ST_WRD_C:  begin ma = rotl64(h_r ^ t_r, 27); mb = PRIME1; end
      ST_QRT_A:  begin ma = {32'd0, tail_r[31:0]}; mb = PRIME1; end
      ST_QRT_B:  begin ma = rotl64(h_r ^ t_r, 23); mb = PRIME2; end
      ST_BYT_A:  begin ma = {56'd0, tail_r[7:0]}; mb = PRIME5; end
      ST_BYT_B:  begin ma = rotl64(h_r ^ t_r, 11); mb = PRIME1; end
      ST_AVL_A:  begin ma = h_r ^ (h_r >> 33); mb = PRIME2; end
      ST_AVL_B:  begin ma = h_r ^ (h_r >> 29); mb = PRIME3; end
      default:   begin ma = t_r; mb = PRIME1; end
    endcase
    mstart = !ph_r;
  end

  // next state of the sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) begin
        if (!in_last || cnt == 4'd8) begin
          st_nxt = (nbuf_r == 2'd3) ? ST_LANE_A : (in_last ? ST_MERGE : ST_IDLE);
        end else begin
          st_nxt = ST_MERGE;
        end
      end
      ST_LANE_A: if (ph_r) st_nxt = ST_LANE_B;
      ST_LANE_B: if (ph_r) begin
        if (idx_r != 2'd3) st_nxt = ST_LANE_A;
        else st_nxt = (tcnt_r[2] ? ST_MERGE : ST_IDLE);
      end
      ST_MERGE:  st_nxt = seen_r ? ST_MRG_A : ST_LEN;
      ST_MRG_A:  if (ph_r) st_nxt = ST_MRG_B;
      ST_MRG_B:  if (ph_r) st_nxt = ST_MRG_C;
      ST_MRG_C:  if (ph_r) st_nxt = (idx_r == 2'd3) ? ST_LEN : ST_MRG_A;
      ST_LEN:    st_nxt = (nbuf_r != 2'd0) ? ST_WRD_A :
                          (tcnt_r[2] ? ST_QRT_A : (tcnt_r != 3'd0 ? ST_BYT_A : ST_AVL_A));
      ST_WRD_A:  if (ph_r) st_nxt = ST_WRD_B;
      ST_WRD_B:  if (ph_r) st_nxt = ST_WRD_C;
      ST_WRD_C:  if (ph_r) begin
        if (idx_r + 2'd1 != nbuf_r) st_nxt = ST_WRD_A;
        else st_nxt = tcnt_r[2] ? ST_QRT_A : (tcnt_r != 3'd0 ? ST_BYT_A : ST_AVL_A);
      end
      ST_QRT_A:  if (ph_r) st_nxt = ST_QRT_B;
      ST_QRT_B:  if (ph_r) st_nxt = (tcnt_r[1:0] != 2'd0) ? ST_BYT_A : ST_AVL_A;
      ST_BYT_A:  if (ph_r) st_nxt = ST_BYT_B;
      ST_BYT_B:  if (ph_r) st_nxt = (tcnt_r == 3'd1) ? ST_AVL_A : ST_BYT_A;
      ST_AVL_A:  if (ph_r) st_nxt = ST_AVL_B;
      ST_AVL_B:  if (ph_r) st_nxt = ST_AVL_C;
      ST_AVL_C:  st_nxt = ST_OUT;
      ST_OUT:    if (out_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_INIT;
      lane_r[0] <= SEED_INIT + PRIME1 + PRIME2;
      lane_r[1] <= SEED_INIT + PRIME2;
      lane_r[2] <= SEED_INIT;
      lane_r[3] <= SEED_INIT - PRIME1;
      nbuf_r <= 2'd0;
      len_r  <= 64'd0;
      seen_r <= 1'b0;
      ph_r   <= 1'b0;
      idx_r  <= 2'd0;
      tcnt_r <= 3'd0;
    end else begin
      if (cfg_we) seed_r <= cfg_wdata;
      if (st_r != ST_IDLE && st_r != ST_MERGE && st_r != ST_LEN &&
          st_r != ST_AVL_C && st_r != ST_OUT) ph_r <= !ph_r;
      unique case (st_r)
        ST_IDLE: if (acc) begin
          idx_r <= 2'd0;
          len_r <= len_r + (in_last ? {60'd0, cnt} : 64'd8);
          // tcnt[2] with a full last word marks "finish after stripe"; a full last
          // word that only joins the buffer leaves no tail
          tcnt_r <= in_last ? (cnt == 4'd8 ? ((nbuf_r == 2'd3) ? 3'd4 : 3'd0) : cnt[2:0])
                            : 3'd0;
          tail_r <= in_data_word & ~(64'hFFFF_FFFF_FFFF_FFFF << {cnt[2:0], 3'b000});
          if (!in_last || cnt == 4'd8) begin
            buf_r[nbuf_r] <= in_data_word;
            nbuf_r <= nbuf_r + 2'd1;
            if (nbuf_r == 2'd3 && !seen_r) begin
              seen_r <= 1'b1;
              lane_r[0] <= seed_r + PRIME1 + PRIME2;
              lane_r[1] <= seed_r + PRIME2;
              lane_r[2] <= seed_r;
              lane_r[3] <= seed_r - PRIME1;
            end
          end
        end
        ST_LANE_A: if (ph_r) t_r <= mp;
        ST_LANE_B: if (ph_r) begin
          lane_r[idx_r] <= mp;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd3) tcnt_r <= 3'd0;
        end
        ST_MERGE: begin
          idx_r <= 2'd0;
          h_r <= seen_r ? rotl64(lane_r[0], 1) + rotl64(lane_r[1], 7) +
                          rotl64(lane_r[2], 12) + rotl64(lane_r[3], 18)
                        : seed_r + PRIME5;
        end
        ST_MRG_A, ST_MRG_B, ST_WRD_A, ST_WRD_B, ST_QRT_A, ST_BYT_A:
          if (ph_r) t_r <= mp;
        ST_MRG_C: if (ph_r) begin
          h_r <= mp + PRIME4;
          idx_r <= idx_r + 2'd1;
        end
        ST_LEN: begin
          h_r <= h_r + len_r;
          idx_r <= 2'd0;
        end
        ST_WRD_C: if (ph_r) begin
          h_r <= mp + PRIME4;
          idx_r <= idx_r + 2'd1;
        end
        ST_QRT_B: if (ph_r) begin
          h_r <= mp + PRIME3;
          tail_r <= tail_r >> 32;
          tcnt_r <= {1'b0, tcnt_r[1:0]};
        end
        ST_BYT_B: if (ph_r) begin
          h_r <= mp;
          tail_r <= tail_r >> 8;
          tcnt_r <= tcnt_r - 3'd1;
        end
        ST_AVL_A, ST_AVL_B: if (ph_r) h_r <= mp;
        ST_AVL_C: begin
          hash_r <= h_r ^ (h_r >> 32);
          nbuf_r <= 2'd0;
          len_r  <= 64'd0;
          seen_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // checks on sequencer behavior
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("result dropped");
  a_ph_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ph_r) else $error("multiplier phase stuck");
endmodule
